@@ sv/psp_pkg.sv @@
// ----------------------------------------------------------------------------
// psp_pkg - shared types and constants of the PSI section parser
// Section byte item, result record, table ids, stream types and field widths.
// ----------------------------------------------------------------------------
package psp_pkg;

   // section kinds tracked while a section is open
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_PAT  = 2'd1;
   localparam logic [1:0] KIND_PMT  = 2'd2;

   // result kinds
   localparam logic ENTRY_PAT = 1'b0;
   localparam logic ENTRY_PMT = 1'b1;

   // table ids
   localparam logic [7:0] TID_PAT = 8'h00;
   localparam logic [7:0] TID_PMT = 8'h02;

   // stream types and descriptor tags
   localparam logic [7:0] ST_VIDEO     = 8'd2;
   localparam logic [7:0] ST_AUDIO_A   = 8'd3;
   localparam logic [7:0] ST_AUDIO_B   = 8'd4;
   localparam logic [7:0] ST_PRIVATE   = 8'd6;
   localparam logic [7:0] TAG_TELETEXT = 8'd86;

   // section byte offsets
   localparam logic [12:0] OFS_LENGTH    = 13'd2;
   localparam logic [12:0] OFS_PROGRAM   = 13'd4;
   localparam logic [12:0] OFS_PAT_FIRST = 13'd8;
   localparam logic [12:0] OFS_INFO_LEN  = 13'd11;
   localparam logic [12:0] OFS_LOOP      = 13'd12;
   localparam logic [12:0] OFS_MAX       = 13'h1FFF;
   localparam logic [13:0] ES_HDR_LAST   = 14'd4;
   localparam logic [13:0] ES_HDR_LEN    = 14'd5;

   localparam int unsigned PAT_CNT_W = 10;

   typedef struct packed {
      logic [7:0] section_byte;
      logic       first_byte;
   } psp_item_type;

   typedef struct packed {
      logic        entry_kind;
      logic [15:0] program_number;
      logic [12:0] main_pid;
      logic [12:0] audio_pid;
      logic        has_teletext;
      logic [7:0]  stream_count;
      logic [2:0]  slot_index;
   } psp_result_type;

endpackage

@@ sv/psp_if.sv @@
// ----------------------------------------------------------------------------
// psp_if - valid/ready channels of the PSI section parser
// Section byte channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface psp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] section_byte;
   logic       first_byte;

   modport source (output valid, output section_byte, output first_byte, input ready);
   modport sink   (input valid, input section_byte, input first_byte, output ready);
endinterface

interface psp_rsp_if;
   logic        valid;
   logic        ready;
   logic        entry_kind;
   logic [15:0] program_number;
   logic [12:0] main_pid;
   logic [12:0] audio_pid;
   logic        has_teletext;
   logic [7:0]  stream_count;
   logic [2:0]  slot_index;

   modport source (output valid, output entry_kind, output program_number,
                   output main_pid, output audio_pid, output has_teletext,
                   output stream_count, output slot_index, input ready);
   modport sink   (input valid, input entry_kind, input program_number,
                   input main_pid, input audio_pid, input has_teletext,
                   input stream_count, input slot_index, output ready);
endinterface

@@ sv/psi_section_parser.sv @@
// ----------------------------------------------------------------------------
// psi_section_parser - MPEG-2 PAT/PMT section parser
// Per-byte parsing of PSI sections into program entries and PMT summaries.
// ----------------------------------------------------------------------------
// Takes one section byte per clock and sustains that rate indefinitely while
// the result side keeps up. A byte is registered on transfer and parsed once
// the result register is free, which also loads its result, if any, into the
// result register. Parsing state updates once per parsed byte; the only
// stall is the result register being full, and req_chan.ready follows
// rsp_chan.ready combinationally. No byte is taken while reset is high. A PAT
// section gives one result per program entry (up to MAX_ENTRIES), a PMT
// section one summary at its last byte while fewer than MAX_ENTRIES PMT
// slots have been used since reset; other table ids are skipped.
module psi_section_parser
   import psp_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 8
)
(
   input  logic       clock,
   input  logic       reset,
   psp_req_if.sink    req_chan,
   psp_rsp_if.source  rsp_chan
);

   logic           hold_valid;
   psp_item_type   hold_item;
   logic           out_free;
   logic           step;
   logic           emit;
   psp_result_type result;

   // a held byte is parsed once the result register can take its output
   assign step = hold_valid && out_free;

   psp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (step),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   psp_parse #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (hold_item),
      .emit   (emit),
      .result (result)
   );

   psp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (step && emit),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ sv/psp_in_stage.sv @@
// ----------------------------------------------------------------------------
// psp_in_stage - input register of the PSI section parser
// Captures one section byte per transfer and hands it to the parser.
// ----------------------------------------------------------------------------
module psp_in_stage
   import psp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   psp_req_if.sink      req_chan,
   input  logic         advance,   // parser consumes the held byte
   output logic         hold_valid,
   output psp_item_type hold_item
);

   logic         valid_ff, valid_in;
   psp_item_type item_ff;

   // take a new byte when empty or when the held one moves on; none in reset
   assign req_chan.ready = !reset && (!valid_ff || advance);
   assign valid_in = req_chan.valid ? 1'b1 : (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= '{section_byte: req_chan.section_byte, first_byte: req_chan.first_byte};
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

@@ sv/psp_parse.sv @@
// ----------------------------------------------------------------------------
// psp_parse - section state and per-byte parsing
// Holds the open section's state, walks PAT entries and the PMT stream loop.
// ----------------------------------------------------------------------------
module psp_parse
   import psp_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 8
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,      // one byte is processed this cycle
   input  psp_item_type   item,
   output logic           emit,
   output psp_result_type result
);

   localparam int unsigned SW = $clog2(MAX_ENTRIES + 1);

   logic [1:0]    active_ff, active_in;
   logic [12:0]   offset_ff, offset_in;
   logic [11:0]   sect_len_ff, sect_len_in;
   logic [11:0]   info_len_ff, info_len_in;
   logic [31:0]   hdr_ff, hdr_in;
   logic [12:0]   next_ofs_ff, next_ofs_in;
   logic [11:0]   es_rem_ff, es_rem_in;
   logic [7:0]    cur_type_ff, cur_type_in;
   logic [SW-1:0] entry_idx_ff, entry_idx_in;
   logic [12:0]   video_ff, video_in;
   logic [12:0]   audio_ff, audio_in;
   logic          ttx_ff, ttx_in;
   logic [7:0]    streams_ff, streams_in;
   logic [SW-1:0] slots_ff, slots_in;
   logic [15:0]   prog_ff, prog_in;

   logic [31:0]          hdr_shift;
   logic [12:0]          b;
   logic [7:0]           byte_val;
   logic [PAT_CNT_W-1:0] pat_cnt;
   logic [PAT_CNT_W-1:0] pat_cap;
   logic [13:0]          start_x;
   logic                 in_es_hdr;
   logic [12:0]          es_pos;
   logic [12:0]          pid;
   logic [11:0]          esl;
   logic [SW+2:0]        slot_ext;
   logic [SW+2:0]        entry_ext;

   assign byte_val  = item.section_byte;
   assign hdr_shift = {hdr_ff[23:0], byte_val};
   assign b         = offset_ff;
   assign start_x   = {1'b0, next_ofs_ff};
   assign slot_ext  = {3'b000, slots_ff};
   assign entry_ext = {3'b000, entry_idx_ff};
   assign pid       = hdr_shift[28:16];
   assign esl       = hdr_shift[11:0];
   assign es_pos    = b - next_ofs_ff;

   // PAT entry count from the section length, capped at the slot count
   always_comb begin
      if (sect_len_in >= 12'd8) begin
         pat_cnt = PAT_CNT_W'((sect_len_in - 12'd8) >> 2);
      end else begin
         pat_cnt = '0;
      end
      if (pat_cnt > PAT_CNT_W'(MAX_ENTRIES)) begin
         pat_cap = PAT_CNT_W'(MAX_ENTRIES);
      end else begin
         pat_cap = pat_cnt;
      end
   end

   // current byte lies in the 5-byte header of an ES loop entry
   assign in_es_hdr = (b >= next_ofs_ff) && ({1'b0, b} <= start_x + ES_HDR_LAST) &&
                      (start_x + ES_HDR_LEN < {2'b00, sect_len_in});

   // next state and result for one byte
   always_comb begin
      active_in    = active_ff;
      offset_in    = offset_ff;
      sect_len_in  = sect_len_ff;
      info_len_in  = info_len_ff;
      hdr_in       = hdr_ff;
      next_ofs_in  = next_ofs_ff;
      es_rem_in    = es_rem_ff;
      cur_type_in  = cur_type_ff;
      entry_idx_in = entry_idx_ff;
      video_in     = video_ff;
      audio_in     = audio_ff;
      ttx_in       = ttx_ff;
      streams_in   = streams_ff;
      slots_in     = slots_ff;
      prog_in      = prog_ff;
      emit         = 1'b0;
      result       = '0;

      if (item.first_byte) begin
         // table id: drop any open section and start over
         offset_in    = 13'd1;
         sect_len_in  = '0;
         info_len_in  = '0;
         hdr_in       = {24'd0, byte_val};
         next_ofs_in  = '0;
         es_rem_in    = '0;
         cur_type_in  = '0;
         entry_idx_in = '0;
         video_in     = '0;
         audio_in     = '0;
         ttx_in       = 1'b0;
         streams_in   = '0;
         prog_in      = '0;
         if (byte_val == TID_PAT) begin
            active_in = KIND_PAT;
         end else if (byte_val == TID_PMT && slots_ff < SW'(MAX_ENTRIES)) begin
            active_in = KIND_PMT;
         end else begin
            active_in = KIND_NONE;
         end
      end else if (active_ff != KIND_NONE) begin
         hdr_in = hdr_shift;
         if (b == OFS_LENGTH) begin
            sect_len_in = hdr_shift[11:0];
         end
         if (b == OFS_PROGRAM) begin
            prog_in = hdr_shift[15:0];
         end

         if (active_ff == KIND_PAT) begin
            // one program entry ends every fourth byte from offset 8
            if (b >= OFS_PAT_FIRST && b[1:0] == 2'b11 &&
                {{(PAT_CNT_W-SW){1'b0}}, entry_idx_ff} < pat_cap) begin
               emit                  = 1'b1;
               result.entry_kind     = ENTRY_PAT;
               result.program_number = hdr_shift[31:16];
               result.main_pid       = hdr_shift[12:0];
               result.slot_index     = entry_ext[2:0];
               entry_idx_in          = entry_idx_ff + 1'b1;
            end
         end else begin
            // PMT stream loop walk
            if (b == OFS_INFO_LEN) begin
               info_len_in = hdr_shift[11:0];
               next_ofs_in = OFS_LOOP + {1'b0, hdr_shift[11:0]};
            end else if (b >= OFS_LOOP) begin
               if (in_es_hdr) begin
                  if (es_pos[2:0] == 3'd0) begin
                     cur_type_in = byte_val;
                  end else if (es_pos[2:0] == 3'd4) begin
                     if (cur_type_ff == ST_AUDIO_A || cur_type_ff == ST_AUDIO_B) begin
                        audio_in = pid;
                     end else if (cur_type_ff == ST_VIDEO) begin
                        video_in = pid;
                     end
                     if (streams_ff != 8'hFF) begin
                        streams_in = streams_ff + 8'd1;
                     end
                     es_rem_in   = esl;
                     cur_type_in = (cur_type_ff == ST_PRIVATE && esl != 12'd0) ?
                                   ST_PRIVATE : 8'd0;
                     next_ofs_in = 13'(start_x + ES_HDR_LEN + {2'b00, esl});
                  end
               end else if (es_rem_ff != 12'd0) begin
                  // only the first descriptor byte of a private stream counts
                  if (cur_type_ff == ST_PRIVATE && byte_val == TAG_TELETEXT) begin
                     ttx_in = 1'b1;
                  end
                  cur_type_in = '0;
                  es_rem_in   = es_rem_ff - 12'd1;
               end
            end
         end

         // last byte of the section (CRC included)
         if (b >= OFS_LENGTH && {1'b0, b} == {2'b00, sect_len_in} + 14'd2) begin
            if (active_ff == KIND_PMT) begin
               emit                  = 1'b1;
               result.entry_kind     = ENTRY_PMT;
               result.program_number = prog_in;
               result.main_pid       = video_in;
               result.audio_pid      = audio_in;
               result.has_teletext   = ttx_in;
               result.stream_count   = streams_in;
               result.slot_index     = slot_ext[2:0];
               if (slots_ff < SW'(MAX_ENTRIES)) begin
                  slots_in = slots_ff + 1'b1;
               end
            end
            active_in = KIND_NONE;
         end

         offset_in = (b != OFS_MAX) ? b + 13'd1 : b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= KIND_NONE;
         offset_ff    <= '0;
         sect_len_ff  <= '0;
         info_len_ff  <= '0;
         hdr_ff       <= '0;
         next_ofs_ff  <= '0;
         es_rem_ff    <= '0;
         cur_type_ff  <= '0;
         entry_idx_ff <= '0;
         video_ff     <= '0;
         audio_ff     <= '0;
         ttx_ff       <= 1'b0;
         streams_ff   <= '0;
         slots_ff     <= '0;
         prog_ff      <= '0;
      end else if (step) begin
         active_ff    <= active_in;
         offset_ff    <= offset_in;
         sect_len_ff  <= sect_len_in;
         info_len_ff  <= info_len_in;
         hdr_ff       <= hdr_in;
         next_ofs_ff  <= next_ofs_in;
         es_rem_ff    <= es_rem_in;
         cur_type_ff  <= cur_type_in;
         entry_idx_ff <= entry_idx_in;
         video_ff     <= video_in;
         audio_ff     <= audio_in;
         ttx_ff       <= ttx_in;
         streams_ff   <= streams_in;
         slots_ff     <= slots_in;
         prog_ff      <= prog_in;
      end
   end

endmodule

@@ sv/psp_out_stage.sv @@
// ----------------------------------------------------------------------------
// psp_out_stage - result register of the PSI section parser
// Holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module psp_out_stage
   import psp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,      // parser step produced a result
   input  psp_result_type result,
   output logic           free,      // register may take a new result
   psp_rsp_if.source      rsp_chan
);

   logic           valid_ff, valid_in;
   psp_result_type data_ff;

   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = free ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.entry_kind     = data_ff.entry_kind;
   assign rsp_chan.program_number = data_ff.program_number;
   assign rsp_chan.main_pid       = data_ff.main_pid;
   assign rsp_chan.audio_pid      = data_ff.audio_pid;
   assign rsp_chan.has_teletext   = data_ff.has_teletext;
   assign rsp_chan.stream_count   = data_ff.stream_count;
   assign rsp_chan.slot_index     = data_ff.slot_index;

endmodule
